// ===== design/i2c_master_bit_sequencer_core_assert.svh =====
// Assertion macros shared by the sequencer RTL.
`ifndef I2C_MASTER_BIT_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define I2CSEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("i2cseq: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define I2CSEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("i2cseq: next-cycle check failed");

`endif

// ===== design/i2cseq_pkg.sv =====
package i2cseq_pkg;

    // Bus operation codes
    typedef enum logic [2:0] {
        MODE_START   = 3'd0,
        MODE_STOP    = 3'd1,
        MODE_TX_BYTE = 3'd2,
        MODE_RX_BYTE = 3'd3,
        MODE_TX_ACK  = 3'd4,
        MODE_RX_ACK  = 3'd5
    } t_mode;

    localparam int unsigned IN_USER_W  = 3;
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_USER_W = 1;
    localparam int unsigned OUT_DATA_W = 16;
    localparam logic [2:0]  LAST_BIT   = 3'd7;

    // One accepted operation
    typedef struct packed {
        t_mode      mode;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic [7:0] sda_levels;
    } t_cmd;

    // Position inside the current operation
    typedef struct packed {
        logic [2:0] bit_idx;
        logic [1:0] phase;
    } t_pos;

    // One line write plus the position that follows it
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       samples_sda;
        logic [7:0] rx_value;
        logic       last;
        t_pos       nxt_pos;
    } t_step;

endpackage

// ===== design/i2cseq_step.sv =====
module i2cseq_step
    import i2cseq_pkg::*;
(
    input  t_cmd i_cmd,
    input  t_pos i_pos,
    input  logic i_scl,
    input  logic i_sda,
    output t_step o_step
);

    always_comb begin
        o_step             = '0;
        o_step.scl_level   = i_scl;
        o_step.sda_level   = i_sda;
        o_step.nxt_pos     = i_pos;
        o_step.nxt_pos.phase = i_pos.phase + 2'd1;

        unique case (i_cmd.mode)
            MODE_START: begin
                case (i_pos.phase)
                    2'd0: o_step.sda_level = 1'b1;
                    2'd1: o_step.scl_level = 1'b1;
                    2'd2: o_step.sda_level = 1'b0;
                    default: begin
                        o_step.scl_level = 1'b0;
                        o_step.last      = 1'b1;
                    end
                endcase
            end
            MODE_STOP: begin
                case (i_pos.phase)
                    2'd0: o_step.sda_level = 1'b0;
                    2'd1: o_step.scl_level = 1'b1;
                    default: begin
                        o_step.sda_level = 1'b1;
                        o_step.last      = 1'b1;
                    end
                endcase
            end
            MODE_TX_BYTE: begin
                case (i_pos.phase)
                    2'd0: o_step.sda_level = i_cmd.tx_byte[~i_pos.bit_idx];
                    2'd1: o_step.scl_level = 1'b1;
                    default: begin
                        // drop SCL, advance to the next bit
                        o_step.scl_level       = 1'b0;
                        o_step.last            = (i_pos.bit_idx == LAST_BIT);
                        o_step.nxt_pos.phase   = 2'd0;
                        o_step.nxt_pos.bit_idx = i_pos.bit_idx + 3'd1;
                    end
                endcase
            end
            MODE_RX_BYTE: begin
                case (i_pos.phase)
                    2'd0: o_step.sda_level = 1'b1;
                    2'd1: begin
                        o_step.scl_level   = 1'b1;
                        o_step.samples_sda = 1'b1;
                    end
                    default: begin
                        // SDA stays released, so the next bit starts at the SCL rise
                        o_step.scl_level       = 1'b0;
                        o_step.nxt_pos.phase   = 2'd1;
                        o_step.nxt_pos.bit_idx = i_pos.bit_idx + 3'd1;
                        if (i_pos.bit_idx == LAST_BIT) begin
                            o_step.last     = 1'b1;
                            o_step.rx_value = i_cmd.sda_levels;
                        end
                    end
                endcase
            end
            MODE_TX_ACK: begin
                case (i_pos.phase)
                    2'd0: o_step.sda_level = i_cmd.ack_to_send;
                    2'd1: o_step.scl_level = 1'b1;
                    default: begin
                        o_step.scl_level = 1'b0;
                        o_step.last      = 1'b1;
                    end
                endcase
            end
            MODE_RX_ACK: begin
                case (i_pos.phase)
                    2'd0: o_step.sda_level = 1'b1;
                    2'd1: begin
                        o_step.scl_level   = 1'b1;
                        o_step.samples_sda = 1'b1;
                    end
                    default: begin
                        o_step.scl_level = 1'b0;
                        o_step.last      = 1'b1;
                        o_step.rx_value  = {7'd0, i_cmd.sda_levels[0]};
                    end
                endcase
            end
            default: o_step.last = 1'b1;
        endcase
    end

endmodule

// ===== design/i2c_master_bit_sequencer_core.sv =====
// The first line write of an item passes the command register and then the result register before it shows on m_axis.
// One line write per cycle while m_axis_tready is high; an item has 3 to 24 line writes.
// The next item is taken in the cycle of the current item's last write; unused codes are dropped with no writes.
// Reset (i_rst_n low, synchronous): idle, output empty, SCL and SDA drive released.
`include "i2c_master_bit_sequencer_core_assert.svh"

module i2c_master_bit_sequencer_core
    import i2cseq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Operation items in
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [2:0] mode
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    // [7:0] tx_byte, [8] ack_to_send, [16:9] sda_levels, [23:17] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Line write items out
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] scl_level, [1] sda_level, [9:2] rx_value, [15:10] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] samples_sda
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    output logic                  m_axis_tlast
);

    // Command register: the operation currently being expanded
    logic        r_busy, n_busy;
    t_cmd        r_cmd,  n_cmd;
    t_pos        r_pos,  n_pos;

    // Current line drive levels
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;

    // Result register
    logic        r_ovalid, n_ovalid;
    t_step       r_out,    n_out;

    t_step       w_step;
    logic        w_out_free;
    logic        w_step_fire;
    logic        w_in_accept;
    logic [2:0]  w_in_mode;
    logic        w_mode_ok;

    i2cseq_step u_step (
        .i_cmd  (r_cmd),
        .i_pos  (r_pos),
        .i_scl  (r_scl),
        .i_sda  (r_sda),
        .o_step (w_step)
    );

    // Result register is free when empty or being drained this cycle
    assign w_out_free  = !r_ovalid || m_axis_tready;
    assign w_step_fire = r_busy && w_out_free;

    // Take a new item when idle, or while the current one emits its final write
    assign s_axis_tready = !r_busy || (w_step_fire && w_step.last);
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    assign w_in_mode = s_axis_tuser;
    assign w_mode_ok = (w_in_mode == MODE_START)   || (w_in_mode == MODE_STOP)   ||
                       (w_in_mode == MODE_TX_BYTE) || (w_in_mode == MODE_RX_BYTE) ||
                       (w_in_mode == MODE_TX_ACK)  || (w_in_mode == MODE_RX_ACK);

    always_comb begin
        n_busy   = r_busy;
        n_cmd    = r_cmd;
        n_pos    = r_pos;
        n_scl    = r_scl;
        n_sda    = r_sda;
        n_ovalid = r_ovalid;
        n_out    = r_out;

        // Drain the result register
        if (m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        // Emit one line write and advance through the operation
        if (w_step_fire) begin
            n_ovalid = 1'b1;
            n_out    = w_step;
            n_scl    = w_step.scl_level;
            n_sda    = w_step.sda_level;
            n_pos    = w_step.nxt_pos;
            if (w_step.last) begin
                n_busy = 1'b0;
            end
        end

        // Load a new operation; unused codes are dropped with no writes
        if (w_in_accept) begin
            n_busy             = w_mode_ok;
            n_cmd.mode         = t_mode'(w_in_mode);
            n_cmd.tx_byte      = s_axis_tdata[7:0];
            n_cmd.ack_to_send  = s_axis_tdata[8];
            n_cmd.sda_levels   = s_axis_tdata[16:9];
            n_pos              = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pos    <= '0;
            r_scl    <= 1'b1;
            r_sda    <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_pos    <= n_pos;
            r_scl    <= n_scl;
            r_sda    <= n_sda;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tuser  = r_out.samples_sda;
    assign m_axis_tdata  = {6'd0, r_out.rx_value, r_out.sda_level, r_out.scl_level};

    // SDA is only ever sampled while SCL is released
    `I2CSEQ_ASSERT_NOW(a_sample_scl_high, i_clk, i_rst_n,
        r_ovalid && r_out.samples_sda, r_out.scl_level)

    // Received data shows only on the final write of an operation
    `I2CSEQ_ASSERT_NOW(a_rx_only_last, i_clk, i_rst_n,
        r_ovalid && !r_out.last, r_out.rx_value == 8'd0)

    // A valid operation code always starts an expansion
    `I2CSEQ_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n,
        w_in_accept && w_mode_ok, r_busy && (r_pos == '0))

    // Only start reaches its fourth phase
    `I2CSEQ_ASSERT_NOW(a_phase_range, i_clk, i_rst_n,
        r_busy && (r_pos.phase == 2'd3), r_cmd.mode == MODE_START)

endmodule
